>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Synthesis builds define SYNTH so that
// every use expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked on every rising clock edge while reset is released.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(name, clk, rst_n, prop, msg)

`define ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

>>> rtl/cct_pkg.sv
`timescale 1ns / 1ps

package cct_pkg;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } t_op;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_time;

    typedef struct packed {
        t_op   op;
        t_time load;
    } t_item;

    // Time after reset.
    localparam t_time TIME_RESET = '{
        year:   14'd2018,
        month:  4'd11,
        day:    5'd24,
        hour:   5'd5,
        minute: 6'd29,
        second: 6'd5
    };

endpackage

>>> rtl/cct_in_stage.sv
`timescale 1ns / 1ps

module cct_in_stage
    import cct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [5:0]  i_load_second,
    input  logic [5:0]  i_load_minute,
    input  logic [4:0]  i_load_hour,
    input  logic [4:0]  i_load_day,
    input  logic [3:0]  i_load_month,
    input  logic [13:0] i_load_year,
    input  logic        i_take,
    output logic        o_valid,
    output t_item       o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    always_comb begin
        n_item.op          = t_op'(i_operation);
        n_item.load.second = i_load_second;
        n_item.load.minute = i_load_minute;
        n_item.load.hour   = i_load_hour;
        n_item.load.day    = i_load_day;
        n_item.load.month  = i_load_month;
        n_item.load.year   = i_load_year;
    end

    // The register refills in the same cycle that its request moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_take) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((!r_valid || i_take) && i_in_valid) begin
            r_item <= n_item;
        end
    end

    assign o_in_stall = r_valid && !i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

endmodule

>>> rtl/cct_next_time.sv
`timescale 1ns / 1ps

module cct_next_time
    import cct_pkg::*;
(
    input  t_time i_cur,
    input  t_item i_item,
    output t_time o_next,
    output logic  o_rolled
);

    // Divisibility by 25 through a reciprocal: floor(y * 5243 / 2^17) is
    // exact for every 14-bit year.
    localparam logic [12:0] DIV25_RECIP = 13'd5243;
    localparam int          DIV25_SHIFT = 17;

    logic [26:0] quot_prod;
    logic [9:0]  quot;
    logic [14:0] quot_x25;
    logic        div_by_25;
    logic        leap;
    logic [4:0]  month_len;
    logic        sec_wrap;
    logic        min_wrap;
    logic        hour_wrap;
    t_time       ticked;

    assign quot_prod = 27'(i_cur.year) * 27'(DIV25_RECIP);
    assign quot      = quot_prod[DIV25_SHIFT +: 10];
    assign quot_x25  = {1'b0, quot, 4'b0000} + {2'b00, quot, 3'b000} + {5'b00000, quot};
    assign div_by_25 = (quot_x25 == {1'b0, i_cur.year});

    // A multiple of 4 is a century only when it is also a multiple of 25,
    // and a multiple of 400 only when it is also a multiple of 16.
    assign leap = (i_cur.year[1:0] == 2'b00) && (!div_by_25 || (i_cur.year[3:0] == 4'b0000));

    always_comb begin
        case (i_cur.month)
            4'd2:                   month_len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
            default:                month_len = 5'd31;
        endcase
    end

    assign sec_wrap  = i_cur.second >= 6'd59;
    assign min_wrap  = i_cur.minute >= 6'd59;
    assign hour_wrap = i_cur.hour >= 5'd23;

    always_comb begin
        ticked = i_cur;
        if (!sec_wrap) begin
            ticked.second = i_cur.second + 6'd1;
        end else begin
            ticked.second = '0;
            if (!min_wrap) begin
                ticked.minute = i_cur.minute + 6'd1;
            end else begin
                ticked.minute = '0;
                if (!hour_wrap) begin
                    ticked.hour = i_cur.hour + 5'd1;
                end else begin
                    ticked.hour = '0;
                    if (i_cur.day >= month_len) begin
                        ticked.day = 5'd1;
                        if (i_cur.month >= 4'd12) begin
                            ticked.month = 4'd1;
                            ticked.year  = (i_cur.year >= 14'd9999) ? '0
                                                                    : i_cur.year + 14'd1;
                        end else begin
                            ticked.month = i_cur.month + 4'd1;
                        end
                    end else begin
                        ticked.day = i_cur.day + 5'd1;
                    end
                end
            end
        end
    end

    always_comb begin
        unique case (i_item.op)
            OP_LOAD: begin
                o_next   = i_item.load;
                o_rolled = 1'b0;
            end
            OP_TICK: begin
                o_next   = ticked;
                o_rolled = sec_wrap && min_wrap && hour_wrap;
            end
            default: begin
                o_next   = ticked;
                o_rolled = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/calendar_clock_tick.sv
`timescale 1ns / 1ps

// Calendar clock with seconds, minutes, hours, day, month and year, Gregorian
// leap years, and a year that wraps from 9999 to 0. Each request is either a
// one-second tick or a load of all six fields, and each returns one result:
// the time after that request plus a flag set when a tick crossed midnight.
// A request is taken every cycle while the output is not stalled. Once taken,
// the request waits in the input register and then moves through the carry
// and month-length logic into the clock registers. The output fields read
// the clock registers directly. While a result is stalled, one more request
// can wait in the input register before the input stalls. After reset the
// time is 05:29:05 on 24 Nov 2018.

`include "assert_macros.svh"

module calendar_clock_tick
    import cct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [5:0]  i_load_second,
    input  logic [5:0]  i_load_minute,
    input  logic [4:0]  i_load_hour,
    input  logic [4:0]  i_load_day,
    input  logic [3:0]  i_load_month,
    input  logic [13:0] i_load_year,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_out_second,
    output logic [5:0]  o_out_minute,
    output logic [4:0]  o_out_hour,
    output logic [4:0]  o_out_day,
    output logic [3:0]  o_out_month,
    output logic [13:0] o_out_year,
    output logic        o_day_rolled
);

    logic  out_free;
    logic  item_valid;
    t_item item;
    logic  advance;
    t_time n_time;
    logic  n_rolled;

    t_time r_time;
    logic  r_out_valid;
    logic  r_rolled;

    assign out_free = !r_out_valid || !i_out_stall;
    assign advance  = item_valid && out_free;

    cct_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_load_second (i_load_second),
        .i_load_minute (i_load_minute),
        .i_load_hour   (i_load_hour),
        .i_load_day    (i_load_day),
        .i_load_month  (i_load_month),
        .i_load_year   (i_load_year),
        .i_take        (out_free),
        .o_valid       (item_valid),
        .o_item        (item)
    );

    cct_next_time u_next_time (
        .i_cur    (r_time),
        .i_item   (item),
        .o_next   (n_time),
        .o_rolled (n_rolled)
    );

    // The clock registers double as the result payload: they change only
    // when a request moves into the output slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= TIME_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_time <= n_time;
            end
            if (out_free) begin
                r_out_valid <= item_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rolled <= n_rolled;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_second = r_time.second;
    assign o_out_minute = r_time.minute;
    assign o_out_hour   = r_time.hour;
    assign o_out_day    = r_time.day;
    assign o_out_month  = r_time.month;
    assign o_out_year   = r_time.year;
    assign o_day_rolled = r_rolled;

    `ASSERT_CLK(a_roll_at_midnight, i_clk, i_rst_n,
                o_out_valid && o_day_rolled |-> o_out_second == 6'd0
                    && o_out_minute == 6'd0 && o_out_hour == 5'd0,
                "day rollover without midnight")
    `ASSERT_CLK(a_advance_fills_out, i_clk, i_rst_n, advance |=> o_out_valid,
                "request lost on its way to the output")
    `ASSERT_CLK(a_blocked_item_held, i_clk, i_rst_n, item_valid && !out_free |=> item_valid,
                "blocked request dropped from the input register")
    `ASSERT_CLK(a_time_held_in_stall, i_clk, i_rst_n,
                o_out_valid && i_out_stall |=> $stable(r_time),
                "clock changed while its result waited")
    `ASSERT_ALWAYS(a_reset_clears_valid, i_clk, !$past(i_rst_n) |-> !o_out_valid,
                   "output valid set right after reset")

endmodule
